// ----- sv/fnmr_pkg.sv -----
// ---------------------------------------------------------------------------
// fnmr_pkg
// Shared codes and types for the FIFO with n-th match replace.
// ---------------------------------------------------------------------------
package fnmr_pkg;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

endpackage

// ----- sv/fnmr_ram.sv -----
// ---------------------------------------------------------------------------
// fnmr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module fnmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fifo_with_nth_match_replace_unit.sv -----
// ---------------------------------------------------------------------------
// fifo_with_nth_match_replace_unit
// Bounded ring-buffer FIFO of 32-bit words with push, pop and replace of the
// n-th occurrence of a match value (or of the last one if there are fewer),
// walking the store from head to tail.
// Push, pop and unused codes: the result is registered on accept; a new
// word is taken every cycle while the result register drains.
// Replace: one store read per cycle through the single RAM read port, reading
// at most fill level entries; the input is stalled until it finishes.
// Reset clears head, count and control state; store contents are not cleared.
module fifo_with_nth_match_replace_unit #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [31:0] value,
  input  logic [7:0]         occurrence,
  input  logic signed [31:0] new_value,
  output logic               out_valid,
  input  logic               out_stall,
  output fnmr_pkg::status_t  status,
  output logic [6:0]         replaced_position,
  output logic [7:0]         fill_level
);

  import fnmr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

  // control state
  state_t        state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          out_valid_next;

  // scan state
  logic [CW-1:0] rd_pos, rd_pos_next;
  logic          cmp_valid, cmp_valid_next;
  logic [AW-1:0] cmp_pos, cmp_pos_next;
  logic [AW-1:0] cmp_slot, cmp_slot_next;
  logic [7:0]    seen, seen_next;
  logic          found, found_next;
  logic [AW-1:0] last_pos, last_pos_next;
  logic [AW-1:0] last_slot, last_slot_next;
  logic [31:0]   match, match_next;
  logic [7:0]    want, want_next;
  logic [31:0]   repl, repl_next;

  // result register
  status_t       status_next;
  logic [6:0]    replaced_position_next;
  logic [7:0]    fill_level_next;

  // store port
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic          in_acc;
  logic          out_take;
  logic          hit;
  logic          finish;
  logic [AW-1:0] push_slot;
  logic [AW-1:0] scan_slot;

  function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = (AW + 1)'(base) + (AW + 1)'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  fnmr_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_take  = out_valid && !out_stall;
  assign in_stall  = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign push_slot = wrap_slot(head, count);
  assign scan_slot = wrap_slot(head, rd_pos);

  always_comb begin
    state_next             = state;
    head_next              = head;
    count_next             = count;
    out_valid_next         = out_valid && !out_take;
    rd_pos_next            = rd_pos;
    cmp_valid_next         = 1'b0;
    cmp_pos_next           = cmp_pos;
    cmp_slot_next          = cmp_slot;
    seen_next              = seen;
    found_next             = found;
    last_pos_next          = last_pos;
    last_slot_next         = last_slot;
    match_next             = match;
    want_next              = want;
    repl_next              = repl;
    status_next            = status;
    replaced_position_next = replaced_position;
    fill_level_next        = fill_level;
    we                     = 1'b0;
    waddr                  = push_slot;
    wdata                  = value;
    raddr                  = scan_slot;
    hit                    = 1'b0;
    finish                 = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          replaced_position_next = '0;
          status_next            = ST_OK;
          unique case (operation)
            OP_PUSH: begin
              out_valid_next = 1'b1;
              if (count == DEPTH_C) begin
                status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_POP: begin
              out_valid_next = 1'b1;
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                head_next  = (head == LAST_IX) ? '0 : head + AW'(1);
                count_next = count - CW'(1);
              end
            end
            OP_REPLACE: begin
              if (occurrence == '0 || count == '0) begin
                out_valid_next = 1'b1;
                status_next    = ST_NOMATCH;
              end else begin
                state_next  = S_SCAN;
                rd_pos_next = '0;
                seen_next   = '0;
                found_next  = 1'b0;
                match_next  = value;
                want_next   = occurrence;
                repl_next   = new_value;
              end
            end
            default: begin
              out_valid_next = 1'b1;
            end
          endcase
          fill_level_next = 8'(count_next);
        end
      end

      S_SCAN: begin
        // issue one read per cycle until the tail is reached
        if (rd_pos < count) begin
          rd_pos_next    = rd_pos + CW'(1);
          cmp_valid_next = 1'b1;
          cmp_pos_next   = rd_pos[AW-1:0];
          cmp_slot_next  = scan_slot;
        end
        if (cmp_valid) begin
          hit = (rdata == match);
          if (hit) begin
            seen_next      = seen + 8'd1;
            found_next     = 1'b1;
            last_pos_next  = cmp_pos;
            last_slot_next = cmp_slot;
          end
          finish = (hit && (seen + 8'd1 == want)) ||
                   (CW'(cmp_pos) == count - CW'(1));
          if (finish) begin
            // drop any reads still in flight
            cmp_valid_next  = 1'b0;
            state_next      = S_IDLE;
            out_valid_next  = 1'b1;
            fill_level_next = 8'(count);
            if (hit || found) begin
              we                     = 1'b1;
              waddr                  = hit ? cmp_slot : last_slot;
              wdata                  = repl;
              status_next            = ST_OK;
              replaced_position_next = hit ? 7'(cmp_pos) : 7'(last_pos);
            end else begin
              status_next            = ST_NOMATCH;
              replaced_position_next = '0;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos            <= rd_pos_next;
    cmp_pos           <= cmp_pos_next;
    cmp_slot          <= cmp_slot_next;
    seen              <= seen_next;
    found             <= found_next;
    last_pos          <= last_pos_next;
    last_slot         <= last_slot_next;
    match             <= match_next;
    want              <= want_next;
    repl              <= repl_next;
    status            <= status_next;
    replaced_position <= replaced_position_next;
    fill_level        <= fill_level_next;
  end

endmodule
